/* rtl/core/lrup_pkg.sv */
// Shared types and constants for the LRU page replacement block.
// Used by the channel interfaces, the page RAM and the top level.
`default_nettype none

package lrup_pkg;

  // payload widths of the channels
  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned FAULT_W = 16;
  localparam int unsigned CFG_W   = 5;

  // default frame count and reset value of the active frame register
  localparam int unsigned   LRUP_FRAMES_DFLT = 16;
  localparam logic [CFG_W-1:0]   ACTIVE_RESET = CFG_W'(4);
  localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lrup_state_e;

endpackage

`default_nettype wire

/* rtl/core/lrup_if.sv */
// Valid/ready channel interfaces: page references in, results out, config writes.
// Depends on lrup_pkg for the payload widths.
`default_nettype none

interface lrup_in_if import lrup_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;
  logic              last;

  modport source (output valid, output page, output last, input ready);
  modport sink   (input valid, input page, input last, output ready);
endinterface

interface lrup_out_if import lrup_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic [FAULT_W-1:0] fault_count;
  logic               end_of_string;

  modport source (output valid, output hit, output slot, output fault_count,
                  output end_of_string, input ready);
  modport sink   (input valid, input hit, input slot, input fault_count,
                  input end_of_string, output ready);
endinterface

interface lrup_cfg_if import lrup_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] active_frames;

  modport source (output valid, output active_frames, input ready);
  modport sink   (input valid, input active_frames, output ready);
endinterface

`default_nettype wire

/* rtl/core/lru_page_replacement.sv */
// LRU page replacement over FRAMES page frames, of which active_frames (clamped to
// 1..FRAMES) take part. A reference is accepted, then the page RAM streams the active
// entries past the comparator (one read a cycle, registered read data), then the
// update state sets the ranks and, on a miss, writes the page in. A stalled result
// holds the update state. A config write restarts the string: frames empty, fault
// count zero. Depends on lrup_pkg, lrup_if, lrup_page_ram.
`default_nettype none

module lru_page_replacement import lrup_pkg::*; #(
  parameter int unsigned FRAMES = LRUP_FRAMES_DFLT
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  lrup_in_if.sink   in_i,
  lrup_out_if.source out_o,
  lrup_cfg_if.sink  cfg_i
);

  localparam int unsigned IW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned RW   = IW;
  localparam int unsigned CW   = $clog2(FRAMES + 1);
  localparam int unsigned CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;
  localparam logic [RW-1:0] RANK_TOP = RW'(FRAMES - 1);

  lrup_state_e state_q, state_d;

  logic [CFG_W-1:0]   active_q, active_d;
  logic [CW-1:0]      n_q, n_d, n_act;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               chk_vld_q, chk_vld_d;
  logic [IW-1:0]      chk_idx_q, chk_idx_d;
  logic [PAGE_W-1:0]  page_q, page_d;
  logic               last_q, last_d;

  logic               hit_q, hit_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  logic [RW-1:0]      hit_rank_q, hit_rank_d;
  logic               empty_q, empty_d;
  logic [IW-1:0]      empty_idx_q, empty_idx_d;
  logic [RW-1:0]      max_rank_q, max_rank_d;
  logic [IW-1:0]      max_idx_q, max_idx_d;

  logic [FRAMES-1:0]  valid_q, valid_d;
  logic [RW-1:0]      rank_q [FRAMES];
  logic [RW-1:0]      rank_d [FRAMES];
  logic [FAULT_W-1:0] fault_q, fault_d, fault_nxt;

  logic               out_valid_q, out_valid_d;
  logic               out_hit_q, out_hit_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic [FAULT_W-1:0] out_fault_q, out_fault_d;
  logic               out_eos_q, out_eos_d;

  logic               out_free;
  logic [IW-1:0]      slot_sel;
  logic [IW-1:0]      rd_addr;
  logic               ram_we;
  logic [PAGE_W-1:0]  rdata;
  logic [CMPW-1:0]    act_ext;
  logic [FRAMES-1:0]  act_mask;

  lrup_page_ram #(
    .DEPTH (FRAMES),
    .AW    (IW)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_sel),
    .wdata_i (page_q),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // clamp the configured count into 1..FRAMES
  always_comb begin
    act_ext = CMPW'(active_q);
    if (act_ext == '0) begin
      n_act = CW'(1);
    end else if (act_ext > CMPW'(FRAMES)) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = CW'(act_ext);
    end
    for (int j = 0; j < FRAMES; j++) begin
      act_mask[j] = (CMPW'(j) < CMPW'(n_act));
    end
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign slot_sel = hit_q ? hit_idx_q : (empty_q ? empty_idx_q : max_idx_q);
  assign rd_addr  = cnt_q[IW-1:0];
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = cnt_q[IW-1:0];
    page_d      = page_q;
    last_d      = last_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_rank_d  = hit_rank_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    max_rank_d  = max_rank_q;
    max_idx_d   = max_idx_q;
    valid_d     = valid_q;
    rank_d      = rank_q;
    fault_d     = fault_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_hit_d   = out_hit_q;
    out_slot_d  = out_slot_q;
    out_fault_d = out_fault_q;
    out_eos_d   = out_eos_q;
    ram_we      = 1'b0;
    in_i.ready  = 1'b0;
    fault_nxt   = fault_q;

    // compare stage: entry chk_idx_q has its page on the RAM output
    if (chk_vld_q) begin
      if (valid_q[chk_idx_q] && rdata == page_q && !hit_q) begin
        hit_d      = 1'b1;
        hit_idx_d  = chk_idx_q;
        hit_rank_d = rank_q[chk_idx_q];
      end
      if (!valid_q[chk_idx_q] && !empty_q) begin
        empty_d     = 1'b1;
        empty_idx_d = chk_idx_q;
      end
      // oldest frame, lowest index on a tie
      if (rank_q[chk_idx_q] > max_rank_q) begin
        max_rank_d = rank_q[chk_idx_q];
        max_idx_d  = chk_idx_q;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d    = ST_SCAN;
          cnt_d      = '0;
          n_d        = n_act;
          page_d     = in_i.page;
          last_d     = in_i.last;
          hit_d      = 1'b0;
          empty_d    = 1'b0;
          max_rank_d = '0;
          max_idx_d  = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_q == n_q) begin
          state_d = ST_UPDATE;
        end else begin
          chk_vld_d = 1'b1;
          cnt_d     = CW'(cnt_q + 1'b1);
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
          for (int j = 0; j < FRAMES; j++) begin
            if (IW'(j) == slot_sel) begin
              rank_d[j] = '0;
            end else if (valid_q[j] && (!hit_q || rank_q[j] < hit_rank_q) &&
                         rank_q[j] < RANK_TOP) begin
              rank_d[j] = RW'(rank_q[j] + 1'b1);
            end
          end
          if (!hit_q) begin
            ram_we            = 1'b1;
            valid_d[slot_sel] = 1'b1;
            if (fault_q != FAULT_MAX) begin
              fault_nxt = FAULT_W'(fault_q + 1'b1);
            end
          end
          fault_d     = fault_nxt;
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_slot_d  = SLOT_W'(slot_sel);
          out_fault_d = fault_nxt;
          out_eos_d   = last_q;
          // end of string: start the next one fresh
          if (last_q) begin
            valid_d = '0;
            rank_d  = '{default: '0};
            fault_d = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a config write restarts the string
    if (cfg_i.valid) begin
      active_d = cfg_i.active_frames;
      valid_d  = '0;
      rank_d   = '{default: '0};
      fault_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= ACTIVE_RESET;
      n_q         <= CW'(1);
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      empty_q     <= 1'b0;
      valid_q     <= '0;
      rank_q      <= '{default: '0};
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      chk_vld_q   <= chk_vld_d;
      hit_q       <= hit_d;
      empty_q     <= empty_d;
      valid_q     <= valid_d;
      rank_q      <= rank_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    page_q      <= page_d;
    last_q      <= last_d;
    hit_idx_q   <= hit_idx_d;
    hit_rank_q  <= hit_rank_d;
    empty_idx_q <= empty_idx_d;
    max_rank_q  <= max_rank_d;
    max_idx_q   <= max_idx_d;
    out_hit_q   <= out_hit_d;
    out_slot_q  <= out_slot_d;
    out_fault_q <= out_fault_d;
    out_eos_q   <= out_eos_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = out_hit_q;
  assign out_o.slot          = out_slot_q;
  assign out_o.fault_count   = out_fault_q;
  assign out_o.end_of_string = out_eos_q;

  // a new result only ever comes out of the update cycle
  a_out_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPDATE))
    else $error("result raised outside the update cycle");

  // no frame outside the active window is ever occupied
  a_valid_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q & ~act_mask) == '0)
    else $error("occupied frame outside the active window");

  // eviction only happens when every active frame is occupied
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && !hit_q && !empty_q) |-> ((valid_q | ~act_mask) == '1))
    else $error("eviction chosen while an active frame is empty");

endmodule

`default_nettype wire

/* rtl/core/lrup_page_ram.sv */
// Page number store: one write port, one read port, registered read data.
// Depends on lrup_pkg for the page width.
`default_nettype none

module lrup_page_ram import lrup_pkg::*; #(
  parameter int unsigned DEPTH = LRUP_FRAMES_DFLT,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [PAGE_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [PAGE_W-1:0] rdata_o
);

  logic [PAGE_W-1:0] mem [DEPTH];
  logic [PAGE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
